/* design/rgb_to_palette_indexer_defines.svh */
// assertion helpers shared by the rtl files
`ifndef RGB_TO_PALETTE_INDEXER_DEFINES_SVH
`define RGB_TO_PALETTE_INDEXER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RTPI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RTPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rtpi_pkg.sv */
package rtpi_pkg;

    // palette capacity and derived widths
    localparam int unsigned PALETTE_ENTRIES = 256;
    localparam int unsigned ADDR_W          = $clog2(PALETTE_ENTRIES);
    localparam int unsigned COUNT_W         = $clog2(PALETTE_ENTRIES + 1);

    // fixed field widths
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COLOR_W  = 16;

    // work queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FOUND = 2'd0,
        STATUS_ADDED = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } back_state_t;

    typedef struct packed {
        logic               start;
        logic [COLOR_W-1:0] color;
    } work_item_t;

    typedef struct packed {
        logic       valid;
        work_item_t item;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // green lsb on top, then blue, green, red upper five bits
    function automatic logic [COLOR_W-1:0] pack_color(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        return {g[0], b[CHAN_W-1:3], g[CHAN_W-1:3], r[CHAN_W-1:3]};
    endfunction

endpackage

/* design/rtpi_if.sv */
// pixel channel
interface rtpi_pixel_if;
    logic                       valid;
    logic                       ready;
    logic                       start_image;
    logic [rtpi_pkg::CHAN_W-1:0] red;
    logic [rtpi_pkg::CHAN_W-1:0] green;
    logic [rtpi_pkg::CHAN_W-1:0] blue;

    modport source (output valid, start_image, red, green, blue, input ready);
    modport sink   (input valid, start_image, red, green, blue, output ready);
endinterface

// result channel
interface rtpi_result_if;
    logic                          valid;
    logic                          ready;
    logic [rtpi_pkg::INDEX_W-1:0]  color_index;
    logic [rtpi_pkg::STATUS_W-1:0] status;
    logic [rtpi_pkg::COLOR_W-1:0]  packed_color;

    modport source (output valid, color_index, status, packed_color, input ready);
    modport sink   (input valid, color_index, status, packed_color, output ready);
endinterface

/* design/rtpi_front.sv */
module rtpi_front (
    rtpi_pixel_if.sink          pixel,
    input  rtpi_pkg::q_stat_t   qstat,
    output rtpi_pkg::push_t     push
);

    // take a pixel whenever the queue has room
    assign pixel.ready = !qstat.full;

    // pack the pixel and hand it to the queue
    assign push.valid      = pixel.valid && !qstat.full;
    assign push.item.start = pixel.start_image;
    assign push.item.color = rtpi_pkg::pack_color(pixel.red, pixel.green, pixel.blue);

endmodule

/* design/rtpi_queue.sv */
`include "rgb_to_palette_indexer_defines.svh"

module rtpi_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rtpi_pkg::push_t        push,
    input  logic                   pop,
    output rtpi_pkg::q_stat_t      stat,
    output rtpi_pkg::work_item_t   head
);

    rtpi_pkg::work_item_t            entries_reg [rtpi_pkg::QUEUE_DEPTH];
    logic [rtpi_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rtpi_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rtpi_pkg::QCNT_W-1:0]     count_reg, count_next;

    // status and head entry
    assign stat.full  = (count_reg == rtpi_pkg::QCNT_W'(rtpi_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = entries_reg[rd_ptr_reg];

    // pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == rtpi_pkg::QPTR_W'(rtpi_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rtpi_pkg::QPTR_W'(rtpi_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entries_reg[wr_ptr_reg] <= push.item;
        end
    end

    `RTPI_ASSERT_IMPL(a_no_push_when_full, push.valid, !stat.full, "push into full queue")
    `RTPI_ASSERT_IMPL(a_no_pop_when_empty, pop, !stat.empty, "pop from empty queue")
    `RTPI_ASSERT_NEXT(a_push_grows, push.valid && !pop,
        count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")

endmodule

/* design/rtpi_back.sv */
`include "rgb_to_palette_indexer_defines.svh"

module rtpi_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rtpi_pkg::work_item_t   head,
    input  rtpi_pkg::q_stat_t      qstat,
    output logic                   pop,
    rtpi_result_if.source          result
);

    rtpi_pkg::back_state_t               state_reg, state_next;
    logic [rtpi_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [rtpi_pkg::COUNT_W-1:0]        issue_idx_reg, issue_idx_next;
    logic                                cmp_valid_reg, cmp_valid_next;
    logic [rtpi_pkg::ADDR_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic [rtpi_pkg::COLOR_W-1:0]        color_reg, color_next;
    logic [rtpi_pkg::COLOR_W-1:0]        rd_data_reg;
    logic                                out_valid_reg, out_valid_next;
    logic [rtpi_pkg::INDEX_W-1:0]        out_index_reg, out_index_next;
    rtpi_pkg::status_t                   out_status_reg, out_status_next;
    logic [rtpi_pkg::COLOR_W-1:0]        out_color_reg, out_color_next;

    logic [rtpi_pkg::COLOR_W-1:0]        palette_mem [rtpi_pkg::PALETTE_ENTRIES];

    logic                                out_free;
    logic                                hit;
    logic                                more;
    logic                                full;
    logic                                rd_en;
    logic                                wr_en;
    logic                                load;
    logic [rtpi_pkg::INDEX_W-1:0]        load_index;
    rtpi_pkg::status_t                   load_status;

    // scan conditions
    assign out_free = !out_valid_reg || result.ready;
    assign hit      = cmp_valid_reg && (rd_data_reg == color_reg);
    assign more     = (issue_idx_reg < count_reg);
    assign full     = (count_reg == rtpi_pkg::COUNT_W'(rtpi_pkg::PALETTE_ENTRIES));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rtpi_pkg::ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = rtpi_pkg::ST_SCAN;
                end
            end
            rtpi_pkg::ST_SCAN:
            begin
                if (load)
                begin
                    state_next = rtpi_pkg::ST_IDLE;
                end
            end
            default: state_next = rtpi_pkg::ST_IDLE;
        endcase
    end

    // state outputs: one palette read per cycle, decide once a hit or the end shows up
    always_comb
    begin
        pop         = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        load        = 1'b0;
        load_index  = '0;
        load_status = rtpi_pkg::STATUS_FOUND;
        unique case (state_reg)
            rtpi_pkg::ST_IDLE:
            begin
                pop = !qstat.empty;
            end
            rtpi_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    load        = out_free;
                    load_index  = rtpi_pkg::INDEX_W'(cmp_idx_reg);
                    load_status = rtpi_pkg::STATUS_FOUND;
                end
                else if (more)
                begin
                    rd_en = 1'b1;
                end
                else if (full)
                begin
                    load        = out_free;
                    load_index  = '0;
                    load_status = rtpi_pkg::STATUS_FULL;
                end
                else
                begin
                    load        = out_free;
                    wr_en       = out_free;
                    load_index  = rtpi_pkg::INDEX_W'(count_reg);
                    load_status = rtpi_pkg::STATUS_ADDED;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // scan and palette bookkeeping
    always_comb
    begin
        count_next     = count_reg;
        issue_idx_next = issue_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        color_next     = color_reg;
        if (pop)
        begin
            if (head.start)
            begin
                count_next = '0;
            end
            issue_idx_next = '0;
            cmp_valid_next = 1'b0;
            color_next     = head.color;
        end
        if (rd_en)
        begin
            issue_idx_next = issue_idx_reg + 1'b1;
            cmp_valid_next = 1'b1;
            cmp_idx_next   = issue_idx_reg[rtpi_pkg::ADDR_W-1:0];
        end
        if (wr_en)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        out_color_next  = out_color_reg;
        if (load)
        begin
            out_valid_next  = 1'b1;
            out_index_next  = load_index;
            out_status_next = load_status;
            out_color_next  = color_reg;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtpi_pkg::ST_IDLE;
            count_reg     <= '0;
            issue_idx_reg <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_idx_reg <= issue_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= cmp_idx_next;
        color_reg      <= color_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
        out_color_reg  <= out_color_next;
    end

    // palette memory, one write or one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            palette_mem[count_reg[rtpi_pkg::ADDR_W-1:0]] <= color_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= palette_mem[issue_idx_reg[rtpi_pkg::ADDR_W-1:0]];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.color_index  = out_index_reg;
    assign result.status       = out_status_reg;
    assign result.packed_color = out_color_reg;

    `RTPI_ASSERT_IMPL(a_read_written_only, rd_en, issue_idx_reg < count_reg,
        "palette read beyond written entries")
    `RTPI_ASSERT_NEXT(a_add_bumps_count, wr_en,
        count_reg == $past(count_reg) + 1'b1, "entry count did not advance on add")
    `RTPI_ASSERT_IMPL(a_full_at_cap, load && (load_status == rtpi_pkg::STATUS_FULL),
        count_reg == rtpi_pkg::COUNT_W'(rtpi_pkg::PALETTE_ENTRIES),
        "overflow reported below capacity")
    `RTPI_ASSERT_NEXT(a_pop_starts_scan, pop,
        (state_reg == rtpi_pkg::ST_SCAN) && !cmp_valid_reg, "scan did not restart on pop")

endmodule

/* design/rgb_to_palette_indexer.sv */
// Converts RGB888 pixels to palette indices while building a palette of packed 16-bit
// colors (bit 15 green lsb, 14..10 blue, 9..5 green, 4..0 red, upper five bits of each).
// Every pixel gives exactly one result: status 0 with the lowest matching index, status 1
// with a newly appended index, or status 2 with index 0 when the palette is full and the
// color is not in it. start_image empties the palette before its own pixel is handled.
// A two-entry queue decouples the packing front from the search back, so pixels are taken
// while a search runs or a result waits. The search walks the single-port palette memory
// one entry per cycle and stops at the first hit or after the last written entry; a miss
// then appends the color or reports a full palette. No clearing pass is needed after reset;
// only entries below the fill count are read.
module rgb_to_palette_indexer (
    input  logic            clk,
    input  logic            rst_n,
    rtpi_pixel_if.sink      pixel,
    rtpi_result_if.source   result
);

    rtpi_pkg::push_t        push;
    rtpi_pkg::q_stat_t      qstat;
    rtpi_pkg::work_item_t   head;
    logic                   pop;

    // pack and enqueue
    rtpi_front u_front (
        .pixel (pixel),
        .qstat (qstat),
        .push  (push)
    );

    // work queue
    rtpi_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .stat  (qstat),
        .head  (head)
    );

    // palette search and append
    rtpi_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .result (result)
    );

endmodule
